/* src/bpl_pkg.sv */
// Package for the bounded positional list: field widths, request and response
// beat layouts, request and status codes, and the per-cell control word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpl_pkg;

    localparam int DATA_W = 32;
    localparam int MODE_W = 3;
    localparam int POS_W  = 8;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND    = 3'd0,
        MODE_DEL_FIRST = 3'd1,
        MODE_DEL_LAST  = 3'd2,
        MODE_DEL_POS   = 3'd3,
        MODE_READ_POS  = 3'd4
    } bpl_mode_e;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } bpl_status_e;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } bpl_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [LEN_W-1:0]         length;
        logic signed [DATA_W-1:0] item_value;
    } bpl_rsp_t;

    typedef struct packed {
        logic load;
        logic shift;
    } bpl_cell_ctrl_t;

endpackage

`default_nettype wire

/* src/bpl_stream_if.sv */
// Valid/ready channel carrying one payload beat per handshake.
// The payload type is set where the channel is instantiated.
`timescale 1ns / 1ps
`default_nettype none

interface bpl_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

/* src/bounded_positional_list.sv */
// Top level of the bounded positional list: request decode, the row of cells,
// the entry count and the registered response. Uses bpl_pkg, bpl_stream_if, bpl_cell.
//
//   Channel  Direction  Payload                            Handshake
//   req      in         mode, value, position              valid / ready
//   rsp      out        status, length, item_value         valid / ready
//
// On a delete, every cell from the selected entry up shifts at once.
// The response appears in the cycle after the request beat is accepted.
// req.ready is low only while a response is held and rsp.ready is low.
// Reset clears the entry count and the response valid; entries need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module bounded_positional_list #(
    parameter int CAPACITY = 64
) (
    input  wire          clk,
    input  wire          rst_n,
    bpl_stream_if.sink   req,
    bpl_stream_if.source rsp
);

    import bpl_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    bpl_rsp_t          rsp_data_reg;
    bpl_rsp_t          rsp_data_next;

    logic              accept;
    logic              do_append;
    logic              do_del;
    logic              do_read;
    logic [IDX_W-1:0]  sel_idx;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] sel_data;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [POS_W-1:0]  pos_m1;
    logic [CNT_W-1:0]  last_idx;
    logic              is_empty;
    logic              is_full;
    logic              pos_bad;

    logic [DATA_W-1:0]    cell_data [CAPACITY];
    bpl_cell_ctrl_t       cell_ctrl [CAPACITY];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign pos_ext  = CMP_W'(req.data.position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_bad  = (req.data.position == '0) || (pos_ext > cnt_ext);
    assign pos_m1   = req.data.position - POS_W'(1);
    assign last_idx = count_reg - CNT_W'(1);

    always_comb
    begin
        do_append = 1'b0;
        do_del    = 1'b0;
        do_read   = 1'b0;
        sel_idx   = '0;
        status    = ST_OK;
        case (req.data.mode)
            MODE_APPEND:
            begin
                if (is_full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    do_append = 1'b1;
                end
            end
            MODE_DEL_FIRST:
            begin
                if (is_empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    do_del = 1'b1;
                end
            end
            MODE_DEL_LAST:
            begin
                if (is_empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    do_del  = 1'b1;
                    sel_idx = last_idx[IDX_W-1:0];
                end
            end
            MODE_DEL_POS, MODE_READ_POS:
            begin
                if (is_empty)
                begin
                    status = ST_EMPTY;
                end
                else if (pos_bad)
                begin
                    status = ST_INVALID;
                end
                else
                begin
                    do_del  = (req.data.mode == MODE_DEL_POS);
                    do_read = (req.data.mode == MODE_READ_POS);
                    sel_idx = IDX_W'(pos_m1);
                end
            end
            default:
            begin
                status = ST_INVALID;
            end
        endcase
    end

    always_comb
    begin
        sel_data = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (sel_idx == IDX_W'(i))
            begin
                sel_data = sel_data | cell_data[i];
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_W-1:0] neigh;

            if (gi < CAPACITY - 1)
            begin : g_mid
                assign neigh = cell_data[gi+1];
            end
            else
            begin : g_end
                assign neigh = cell_data[gi];
            end

            assign cell_ctrl[gi].load  = accept && do_append
                                         && (count_reg == CNT_W'(gi));
            assign cell_ctrl[gi].shift = accept && do_del && (IDX_W'(gi) >= sel_idx);

            bpl_cell u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl[gi]),
                .app_value  (req.data.value),
                .neigh_data (neigh),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (do_append)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if (do_del)
            begin
                count_next = count_reg - CNT_W'(1);
            end
            rsp_valid_next           = 1'b1;
            rsp_data_next.status     = status;
            rsp_data_next.length     = LEN_W'(count_next);
            rsp_data_next.item_value = (do_del || do_read) ? sel_data : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("Entry count exceeds capacity.");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("Accepted request gave no response.");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && do_append |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("Append did not grow the list by one.");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({do_append, do_del, do_read}))
        else $error("More than one list action decoded.");

    a_err_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (status != ST_OK) |=> $stable(count_reg))
        else $error("Rejected request changed the entry count.");

endmodule

`default_nettype wire

/* src/bpl_cell.sv */
// One storage cell of the list row: holds a single entry and either loads an
// appended value or takes its right-hand neighbour's entry. Uses bpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpl_cell (
    input  wire                           clk,
    input  bpl_pkg::bpl_cell_ctrl_t       ctrl,
    input  wire [bpl_pkg::DATA_W-1:0]     app_value,
    input  wire [bpl_pkg::DATA_W-1:0]     neigh_data,
    output logic [bpl_pkg::DATA_W-1:0]    data
);

    import bpl_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = app_value;
        end
        else if (ctrl.shift)
        begin
            data_next = neigh_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* tb/sv/tb_bounded_positional_list.sv */
// Self-checking testbench for bounded_positional_list: a scoreboard class keeps its own
// copy of the list, predicts every response beat and compares each field on arrival.
// Depends on bpl_pkg, bpl_stream_if and the bounded_positional_list RTL.
`timescale 1ns / 1ps

module tb_bounded_positional_list;

    import bpl_pkg::*;

    localparam int CAP = 64;
    localparam int RANDOM_ITEMS = 400;
    localparam int LIMIT = 400000;
    localparam int SETTLE = 8;
    localparam logic [MODE_W-1:0] MODE_UNKNOWN_LO = MODE_W'(MODE_READ_POS + 1);
    localparam logic [MODE_W-1:0] MODE_UNKNOWN_HI = '1;

    class list_scoreboard #(int DEPTH = 64);
        logic signed [DATA_W-1:0] cells [DEPTH];
        int unsigned              count;
        bpl_rsp_t                 pending [$];
        int unsigned              errors;

        function new();
            count = 0;
            errors = 0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 20)
                $display("mismatch: %s", msg);
        endtask

        function logic signed [DATA_W-1:0] take(int unsigned idx);
            logic signed [DATA_W-1:0] v;
            v = cells[idx];
            for (int unsigned i = idx; i + 1 < count; i++)
                cells[i] = cells[i + 1];
            count--;
            return v;
        endfunction

        function void note_request(bpl_req_t r);
            bpl_rsp_t e;
            e.status = ST_OK;
            e.item_value = '0;
            if (r.mode == MODE_APPEND)
            begin
                if (count >= DEPTH)
                    e.status = ST_FULL;
                else
                begin
                    cells[count] = r.value;
                    count++;
                end
            end
            else if (r.mode > MODE_READ_POS)
                e.status = ST_INVALID;
            else if (count == 0)
                e.status = ST_EMPTY;
            else if (r.mode == MODE_DEL_FIRST)
                e.item_value = take(0);
            else if (r.mode == MODE_DEL_LAST)
                e.item_value = take(count - 1);
            else if (r.position == 0 || r.position > count)
                e.status = ST_INVALID;
            else if (r.mode == MODE_DEL_POS)
                e.item_value = take(r.position - 1);
            else
                e.item_value = cells[r.position - 1];
            e.length = count[LEN_W-1:0];
            pending.push_back(e);
        endfunction

        task check_response(bpl_rsp_t got);
            bpl_rsp_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("response beat with none expected: status %0d length %0d %s %0d",
                                 got.status, got.length, "value", got.item_value));
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.length !== want.length)
                report($sformatf("length %0d, expected %0d", got.length, want.length));
            if (got.item_value !== want.item_value)
                report($sformatf("item_value %0d, expected %0d",
                                 got.item_value, want.item_value));
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   src_quiet;
    bit   snk_quiet;
    int   stall_left;
    int   cycles;
    int   sent;

    list_scoreboard #(CAP) sb;

    bpl_stream_if #(.payload_t(bpl_req_t)) req_if ();
    bpl_stream_if #(.payload_t(bpl_rsp_t)) rsp_if ();

    bounded_positional_list #(.CAPACITY(CAP)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic bpl_req_t make_req(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value,
                                          logic [POS_W-1:0] position);
        bpl_req_t r;
        r.mode = mode;
        r.value = value;
        r.position = position;
        return r;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 18)
            return POS_W'($urandom_range(0, 255));
        if (r < 25)
            return POS_W'(sb.count + 1);
        return POS_W'($urandom_range(1, (sb.count == 0) ? 1 : sb.count));
    endfunction

    task automatic send_request(input bpl_req_t r);
        int gap;
        gap = src_quiet ? 0 : pick_gap();
        if (gap != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= r;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sb.note_request(r);
        sent++;
    endtask

    task automatic fill_list();
        while (sb.count < CAP)
            send_request(make_req(MODE_APPEND, $urandom, pick_position()));
        repeat (2) send_request(make_req(MODE_APPEND, $urandom, pick_position()));
        send_request(make_req(MODE_READ_POS, $urandom, POS_W'(CAP)));
        send_request(make_req(MODE_READ_POS, $urandom, POS_W'(CAP + 1)));
        send_request(make_req(MODE_DEL_POS, $urandom, POS_W'(CAP)));
    endtask

    task automatic drain_list();
        int r;
        while (sb.count > 0)
        begin
            r = $urandom_range(0, 2);
            if (r == 0)
                send_request(make_req(MODE_DEL_FIRST, $urandom, pick_position()));
            else if (r == 1)
                send_request(make_req(MODE_DEL_LAST, $urandom, pick_position()));
            else
                send_request(make_req(MODE_DEL_POS, $urandom,
                                      POS_W'($urandom_range(1, sb.count))));
        end
        send_request(make_req(MODE_W'($urandom_range(MODE_DEL_FIRST, MODE_READ_POS)),
                              $urandom, POS_W'($urandom_range(0, 255))));
    endtask

    task automatic mixed_run(int n);
        int r;
        logic [MODE_W-1:0] mode;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                mode = MODE_APPEND;
            else if (r < 50)
                mode = MODE_DEL_FIRST;
            else if (r < 60)
                mode = MODE_DEL_LAST;
            else if (r < 75)
                mode = MODE_DEL_POS;
            else if (r < 95)
                mode = MODE_READ_POS;
            else
                mode = MODE_W'($urandom_range(MODE_UNKNOWN_LO, MODE_UNKNOWN_HI));
            send_request(make_req(mode, $urandom, pick_position()));
        end
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.data);
        if ($urandom_range(0, 63) == 0)
            snk_quiet = !snk_quiet;
        if (stall_left != 0)
            stall_left--;
        else if (!snk_quiet && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
        rsp_if.ready <= (stall_left == 0);
    end

    initial
    begin
        int seg;
        sb = new();
        cycles = 0;
        sent = 0;
        stall_left = 0;
        src_quiet = 1'b0;
        snk_quiet = 1'b0;
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Requests on the empty list, then small lists around the position limits.
        send_request(make_req(MODE_DEL_FIRST, '0, 8'd1));
        send_request(make_req(MODE_DEL_LAST, '0, 8'd1));
        send_request(make_req(MODE_DEL_POS, '0, 8'd0));
        send_request(make_req(MODE_READ_POS, '0, 8'd255));
        send_request(make_req(MODE_UNKNOWN_HI, '1, 8'd1));
        send_request(make_req(MODE_APPEND, 32'h7FFF_FFFF, 8'd0));
        send_request(make_req(MODE_APPEND, 32'h8000_0000, 8'd255));
        send_request(make_req(MODE_APPEND, '0, 8'd1));
        send_request(make_req(MODE_READ_POS, '0, 8'd0));
        send_request(make_req(MODE_READ_POS, '0, 8'd4));
        send_request(make_req(MODE_READ_POS, '0, 8'd255));
        send_request(make_req(MODE_READ_POS, '0, 8'd1));
        send_request(make_req(MODE_READ_POS, '0, 8'd3));
        send_request(make_req(MODE_DEL_POS, '0, 8'd2));
        send_request(make_req(MODE_DEL_LAST, '0, 8'd1));
        send_request(make_req(MODE_READ_POS, '0, 8'd2));
        send_request(make_req(MODE_DEL_POS, '0, 8'd2));
        send_request(make_req(MODE_UNKNOWN_LO, '0, 8'd1));
        send_request(make_req(MODE_DEL_POS, '0, 8'd1));
        send_request(make_req(MODE_APPEND, '1, 8'd1));
        send_request(make_req(MODE_APPEND, 32'd1, 8'd1));
        send_request(make_req(MODE_DEL_FIRST, '0, 8'd1));
        send_request(make_req(MODE_DEL_POS, '0, 8'd1));

        sent = 0;
        fill_list();
        while (sent < RANDOM_ITEMS)
        begin
            src_quiet = ($urandom_range(0, 3) == 0);
            seg = $urandom_range(0, 9);
            if (seg == 0)
                fill_list();
            else if (seg < 3)
                drain_list();
            else
                mixed_run($urandom_range(10, 40));
        end
        req_if.valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
